FILE: rtl/core/cdq_pkg.sv
// Package for the circular deque core: depth, index widths, command and
// status codes, and the structs passed between the controller and the top.
// No dependencies.
`default_nettype none

package cdq_pkg;

  // Queue depth, the index and count widths that follow from it, and the data and occupancy widths.
  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Request from the controller to the entry memory.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  // Result of one word, minus the popped data that the memory returns later.
  typedef struct packed {
    status_t           status;
    logic              pop_ok;
    logic [OCC_W-1:0]  occupancy;
  } res_info_t;

  // Step an index down by one with wrap.
  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    idx_dec = (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  // Step an index up by one with wrap.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    idx_inc = (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cdq_ram.sv
// Single-port synchronous RAM with registered read data, read-first.
// Generic; used by the deque core for its entry storage.
`default_nettype none

module cdq_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write and read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdq_ctrl.sv
// Deque controller: front and rear indices and element count, command
// decode, and the memory request for each accepted word. Uses cdq_pkg.
`default_nettype none

module cdq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [1:0]                    command,
  input  wire logic [cdq_pkg::DATA_W-1:0]    push_value,
  output cdq_pkg::mem_req_t                  mem_req,
  output cdq_pkg::res_info_t                 res_info
);

  logic [cdq_pkg::IDX_W-1:0] front_r, front_nxt;
  logic [cdq_pkg::IDX_W-1:0] rear_r, rear_nxt;
  logic [cdq_pkg::CNT_W-1:0] count_r, count_nxt;

  // Decode the command against the current indices and count.
  always_comb begin
    front_nxt         = front_r;
    rear_nxt          = rear_r;
    count_nxt         = count_r;
    mem_req.wr_en     = 1'b0;
    mem_req.rd_en     = 1'b0;
    mem_req.addr      = front_r;
    mem_req.wdata     = push_value;
    res_info.status   = cdq_pkg::ST_DONE;
    res_info.pop_ok   = 1'b0;

    unique case (cdq_pkg::cmd_t'(command))
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
        if (count_r == cdq_pkg::CNT_FULL) begin
          res_info.status = cdq_pkg::ST_FULL;
        end else begin
          mem_req.wr_en = 1'b1;
          count_nxt     = count_r + cdq_pkg::CNT_W'(1);
          if (count_r == '0) begin
            // First element always lands in entry zero.
            front_nxt    = '0;
            rear_nxt     = '0;
            mem_req.addr = '0;
          end else if (cdq_pkg::cmd_t'(command) == cdq_pkg::CMD_PUSH_FRONT) begin
            front_nxt    = cdq_pkg::idx_dec(front_r);
            mem_req.addr = front_nxt;
          end else begin
            rear_nxt     = cdq_pkg::idx_inc(rear_r);
            mem_req.addr = rear_nxt;
          end
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
        if (count_r == '0) begin
          res_info.status = cdq_pkg::ST_EMPTY;
        end else begin
          mem_req.rd_en   = 1'b1;
          res_info.pop_ok = 1'b1;
          count_nxt       = count_r - cdq_pkg::CNT_W'(1);
          if (cdq_pkg::cmd_t'(command) == cdq_pkg::CMD_POP_FRONT) begin
            mem_req.addr = front_r;
            front_nxt    = cdq_pkg::idx_inc(front_r);
          end else begin
            mem_req.addr = rear_r;
            rear_nxt     = cdq_pkg::idx_dec(rear_r);
          end
          // Removing the last element sends both indices home.
          if (count_r == cdq_pkg::CNT_W'(1)) begin
            front_nxt = '0;
            rear_nxt  = '0;
          end
        end
      end
      default: begin
      end
    endcase

    res_info.occupancy = cdq_pkg::OCC_W'(count_nxt);

    // Nothing touches the memory unless the word is taken.
    if (!accept) begin
      mem_req.wr_en = 1'b0;
      mem_req.rd_en = 1'b0;
    end
  end

  // Index and count registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/circular_deque_core.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_command, in_push_value
// out_     output     out_valid/out_stall  out_status, out_popped_value, out_occupancy
//
// One word is accepted per cycle while in_stall is low; its result passes
// through the pending stage, where the registered memory read lands, and then the output register.
// Indices and count update at the accept edge, so back-to-back words on the
// same entry need no forwarding. Reset clears indices, count and valids only.
// A stalled result holds in the output register; one more result waits
// behind it, and only then does in_stall rise.
//
// Top level of the circular deque. Uses cdq_pkg, cdq_ctrl and cdq_ram.
`default_nettype none

module circular_deque_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [31:0] in_push_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_popped_value,
  output logic [4:0]              out_occupancy
);

  cdq_pkg::mem_req_t          mem_req;
  cdq_pkg::res_info_t         res_info;
  logic [cdq_pkg::DATA_W-1:0] rd_data;

  logic                       in_acc;
  logic                       s1_move;
  logic                       s1_v_r, s1_v_nxt;
  cdq_pkg::res_info_t         s1_res_r;
  logic                       out_v_r, out_v_nxt;
  logic [1:0]                 out_status_r;
  logic [cdq_pkg::DATA_W-1:0] out_popped_r;
  logic [4:0]                 out_occ_r;

  // Handshake: the pending result moves on when the output register frees.
  assign s1_move  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && out_v_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .command    (in_command),
    .push_value (in_push_value),
    .mem_req    (mem_req),
    .res_info   (res_info)
  );

  cdq_ram #(
    .DATA_W (cdq_pkg::DATA_W),
    .ADDR_W (cdq_pkg::IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .rd_en   (mem_req.rd_en),
    .addr    (mem_req.addr),
    .wdata   (mem_req.wdata),
    .rd_data (rd_data)
  );

  // Valid bits of the pending stage and the output register.
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (s1_move) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers. Read data stays put until the next accepted pop.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= res_info;
    end
    if (s1_move) begin
      out_status_r <= s1_res_r.status;
      out_popped_r <= s1_res_r.pop_ok ? rd_data : '0;
      out_occ_r    <= s1_res_r.occupancy;
    end
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_occupancy    = out_occ_r;

endmodule

`default_nettype wire

FILE: rtl/core/cdq_checker.sv
// Port-level checker for the circular deque core, with its bind statement.
// Uses cdq_pkg; attaches to circular_deque_core.
`default_nettype none

module cdq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic signed [31:0] out_popped_value,
  input wire logic [4:0]         out_occupancy
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_popped_value) && $stable(out_occupancy))
    else $error("result word changed while stalled");

  // Only a successful pop carries data.
  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cdq_pkg::ST_DONE |-> out_popped_value == 0)
    else $error("refused word carries popped data");

  // A refused pop means the queue is empty.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cdq_pkg::ST_EMPTY |-> out_occupancy == 5'd0)
    else $error("empty status with nonzero occupancy");

  // A refused push means the queue is full.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cdq_pkg::ST_FULL |->
    out_occupancy == 5'(cdq_pkg::DEPTH))
    else $error("full status with wrong occupancy");

  // No result leaves right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_popped_value (out_popped_value),
  .out_occupancy    (out_occupancy)
);

`default_nettype wire

FILE: tb/sv/circular_deque_checker.sv
// Scoreboard for the circular deque core: watches both channels, predicts each
// result word from the accepted input words and compares field by field.
// Depends on cdq_pkg for the depth, widths, command and status codes.
module circular_deque_checker
  import cdq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [31:0] in_push_value,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         out_status,
  input  wire logic signed [31:0] out_popped_value,
  input  wire logic [4:0]         out_occupancy,
  output int                      fail_count,
  output int                      results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] popped;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  // Shadow copy of the deque contents and pointers.
  logic [DATA_W-1:0] entries [DEPTH];
  logic [IDX_W-1:0]  front_idx = '0;
  logic [IDX_W-1:0]  rear_idx  = '0;
  int unsigned       held      = 0;

  deque_result_t expected_results [$];
  int            errors_seen  = 0;
  int            queued_count = 0;

  assign fail_count          = errors_seen;
  assign results_outstanding = queued_count;

  initial begin
    foreach (entries[i]) entries[i] = '0;
  end

  // Apply one command to the shadow deque and return the result word it causes.
  function automatic deque_result_t apply_command(input cmd_t cmd,
                                                  input logic [DATA_W-1:0] value);
    deque_result_t res;
    res.status = ST_DONE;
    res.popped = '0;
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
      if (held >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // The first element of an empty deque always lands in entry zero.
        if (held == 0) begin
          front_idx  = '0;
          rear_idx   = '0;
          entries[0] = value;
        end else if (cmd == CMD_PUSH_FRONT) begin
          front_idx = (front_idx == '0) ? IDX_LAST : front_idx - 1'b1;
          entries[front_idx] = value;
        end else begin
          rear_idx = (rear_idx == IDX_LAST) ? '0 : rear_idx + 1'b1;
          entries[rear_idx] = value;
        end
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        if (cmd == CMD_POP_FRONT) begin
          res.popped = entries[front_idx];
          front_idx  = (front_idx == IDX_LAST) ? '0 : front_idx + 1'b1;
        end else begin
          res.popped = entries[rear_idx];
          rear_idx   = (rear_idx == '0) ? IDX_LAST : rear_idx - 1'b1;
        end
        held--;
        // Removing the last element sends both pointers home.
        if (held == 0) begin
          front_idx = '0;
          rear_idx  = '0;
        end
      end
    end
    res.occupancy = OCC_W'(held);
    return res;
  endfunction

  // Check result words against the oldest prediction, then predict new ones.
  always @(posedge clk) begin
    deque_result_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      held      = 0;
      front_idx = '0;
      rear_idx  = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: stray result word, expected none, actual %0d/%0d/%0d",
                   $time, out_status, out_popped_value, out_occupancy);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            errs++;
          end
          if (out_popped_value !== want.popped) begin
            $display("%0t: popped value mismatch, expected %0d, actual %0d",
                     $time, want.popped, out_popped_value);
            errs++;
          end
          if (out_occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                     $time, want.occupancy, out_occupancy);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_command(cmd_t'(in_command), in_push_value));
      end
    end
    if (errs != 0) errors_seen <= errors_seen + errs;
    queued_count <= expected_results.size();
  end

endmodule

FILE: tb/sv/circular_deque_core_tb.sv
// Top of the circular deque testbench: clock, reset, input and output stimulus,
// and the final verdict. Depends on cdq_pkg, circular_deque_core and
// circular_deque_checker.
module circular_deque_core_tb
  import cdq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 600;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 8;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic [1:0]         in_command    = CMD_POP_FRONT;
  logic signed [31:0] in_push_value = '0;
  logic               out_stall     = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [31:0] out_popped_value;
  logic [4:0]         out_occupancy;

  int fail_count;
  int results_outstanding;

  // Stimulus controls set by the sender; quiet and hold_request also steer the receiver.
  bit quiet        = 1'b0;
  bit no_gaps      = 1'b0;
  bit hold_request = 1'b0;

  // Occupancy as seen from the sender, used to steer the command mix.
  int level       = 0;
  int words_sent  = 0;
  int full_denied = 0;
  int empty_denied = 0;

  circular_deque_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_occupancy    (out_occupancy)
  );

  circular_deque_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_push_value       (in_push_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_popped_value    (out_popped_value),
    .out_occupancy       (out_occupancy),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word, with an occasional idle burst in front, and wait for it to go in.
  task automatic offer(input cmd_t cmd, input logic [31:0] value);
    if (!quiet && !no_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
      if (level == DEPTH) full_denied++;
      else level++;
    end else begin
      if (level == 0) empty_denied++;
      else level--;
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin : receiver
    int   stall_left;
    int   run_left;
    int   hold_left;
    logic stall_next;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else if (quiet) begin
        stall_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_next = 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        stall_next = 1'b0;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_next = 1'b1;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        stall_next = 1'b0;
        run_left   = $urandom_range(1, 40) - 1;
      end
      out_stall <= stall_next;
    end
  end

  // Sender: reset, directed words, then random sequences that sweep the fill level.
  initial begin : stimulus
    int          pick;
    bit          filling;
    bit          push;
    cmd_t        cmd;
    logic [31:0] value;
    filling = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Pops from an empty deque are refused.
    offer(CMD_POP_FRONT, 32'h1234_5678);
    offer(CMD_POP_REAR,  32'h8765_4321);
    // Single element in and out from each end, with the extreme values.
    offer(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    offer(CMD_POP_REAR,   32'h0000_0000);
    offer(CMD_PUSH_REAR,  32'h8000_0000);
    offer(CMD_POP_FRONT,  32'hFFFF_FFFF);
    // Fill from both ends so the front pointer wraps, then push into the full deque.
    offer(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    offer(CMD_PUSH_FRONT, 32'h0000_0000);
    offer(CMD_PUSH_REAR,  32'h5555_5555);
    offer(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    offer(CMD_PUSH_REAR,  32'h7FFF_FFFF);
    offer(CMD_PUSH_FRONT, 32'h8000_0000);
    for (int i = 0; i < 10; i++) begin
      offer((i % 2 == 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, $urandom);
    end
    offer(CMD_PUSH_FRONT, 32'h0F0F_0F0F);
    offer(CMD_PUSH_REAR,  32'hF0F0_F0F0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Long output hold-off while the sender keeps offering words back to back.
      if (i == 200) begin
        hold_request = 1'b1;
        no_gaps      = 1'b1;
      end
      if (i == 240) no_gaps = 1'b0;
      if (i == RANDOM_WORDS - 60) quiet = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        cmd = cmd_t'($urandom_range(0, 3));
      end else begin
        // Mostly fill until full, then mostly drain until empty.
        if (filling && level == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
        else if (!filling && level == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
        push = filling ? (pick % 4 != 0) : (pick % 4 == 0);
        if (push) cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        else      cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
      end
      case ($urandom_range(0, 9))
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = 32'h0000_0000;
        3:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      offer(cmd, value);
    end
    in_valid <= 1'b0;

    // Let every predicted result word come out, then watch for strays.
    repeat (2) @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words; %0d pushes met a full deque, %0d pops an empty one.",
             words_sent, full_denied, empty_denied);
    $display("Included a %0d-cycle output hold-off that backed up the input side.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/cdq_ctrl.sv
rtl/core/circular_deque_core.sv
rtl/core/cdq_checker.sv
tb/sv/circular_deque_checker.sv
tb/sv/circular_deque_core_tb.sv
